[rtl/olpt_pkg.sv]
// Shared types and constants of the online perceptron trainer.
// Holds the channel payload structs, action codes, controller states and
// the command/status bundles between controller and datapath.
package olpt_pkg;

  localparam int NUM_FEATURES = 8;
  localparam int FEATURE_BITS = 16;
  localparam int FEAT_FRAC    = FEATURE_BITS - 4;
  localparam int ETA_BITS     = 16;
  localparam int ERR_BITS     = ETA_BITS + 2;

  localparam logic [ETA_BITS-1:0] ETA_RESET = 16'd655;

  localparam logic [1:0] ACT_TRAIN   = 2'd0;
  localparam logic [1:0] ACT_PREDICT = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  typedef logic signed [FEATURE_BITS-1:0] feature_t;

  typedef struct packed {
    logic [1:0] action;
    feature_t   feature_0;
    feature_t   feature_1;
    feature_t   feature_2;
    feature_t   feature_3;
    feature_t   feature_4;
    feature_t   feature_5;
    feature_t   feature_6;
    feature_t   feature_7;
    logic       target_class;
  } in_item_t;

  typedef struct packed {
    logic predicted_class;
    logic weights_changed;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SIGN,
    S_UPD,
    S_CLR,
    S_RES
  } state_t;

  typedef struct packed {
    logic load;
    logic clear;
    logic mac;
    logic decide;
    logic upd;
    logic res_load;
  } cmd_t;

  typedef struct packed {
    logic cnt_done;
    logic need_update;
  } sts_t;

endpackage

[rtl/online_perceptron_trainer_top.sv]
// Online perceptron trainer, fixed-point Rosenblatt learning rule.
// Each input transfer carries an action (train, predict, clear), eight
// signed Q4.12 features and a target class; each yields one result transfer
// with the class predicted from the weights held before the item and a flag
// that a train item changed the weights (a clear returns both as zero).
// The cfg channel writes the learning rate (Q0.16) and is always ready;
// write it only while no item is in flight. The dot product runs through
// one multiply-accumulate lane, one feature per cycle; a train item that
// misclassifies, with a nonzero rate, then updates the weights through the
// correction multiplier, and a clear item only zeroes weights, bias and
// result flags. The result is loaded into the output register.
// One item is in flight at a time; in_ready is high only when idle.
// A finished result waits in the output register; if the receiver stalls,
// the block accepts the next item and holds its result until the register
// frees. Reset zeroes weights and bias and sets the learning rate to 655.
// Depends on olpt_pkg, olpt_ctrl and olpt_datapath.
module online_perceptron_trainer_top import olpt_pkg::*; #(
  parameter int WEIGHT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [ETA_BITS-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  olpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  olpt_datapath #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[rtl/olpt_datapath.sv]
// Datapath of the online perceptron trainer: weight and bias registers,
// one shared multiply-accumulate lane for the dot product, a correction
// multiplier with saturating add, and the result register. Uses olpt_pkg.
module olpt_datapath import olpt_pkg::*; #(
  parameter int WEIGHT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [ETA_BITS-1:0] cfg_data,
  input  in_item_t            in_data,
  input  cmd_t                cmd,
  output sts_t                sts,
  output out_item_t           out_data
);

  localparam int WB      = WEIGHT_BITS;
  localparam int PB      = WB + FEATURE_BITS;
  localparam int BIAS_W  = WB + FEAT_FRAC;
  localparam int EXACT_W = ((PB > BIAS_W) ? PB : BIAS_W) + $clog2(NUM_FEATURES + 1) + 1;
  // Past 64 bits the sum wraps, and only bit 63 decides the class.
  localparam int AW      = (EXACT_W > 64) ? 64 : EXACT_W;
  localparam int DPB     = ERR_BITS + FEATURE_BITS;
  localparam int DW      = DPB - FEAT_FRAC;
  localparam int SW      = ((WB > DW) ? WB : DW) + 1;
  localparam int CW      = $clog2(NUM_FEATURES + 1);
  localparam int IW      = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(NUM_FEATURES);

  logic signed [WB-1:0]       weight_r [NUM_FEATURES];
  logic signed [WB-1:0]       bias_r;
  logic [ETA_BITS-1:0]        eta_r;
  logic [CW-1:0]              cnt_r;
  logic                       pred_r;
  logic                       changed_r;

  feature_t                   feat_r [NUM_FEATURES];
  feature_t                   feat_in [NUM_FEATURES];
  logic [1:0]                 action_r;
  logic                       target_r;
  logic signed [PB-1:0]       prod_r;
  logic signed [AW-1:0]       acc_r;
  logic signed [ERR_BITS-1:0] err_r;
  logic signed [DPB-1:0]      dprod_r;
  logic [IW-1:0]              upd_idx_r;
  out_item_t                  out_r;

  logic [IW-1:0]              idx;
  logic signed [WB-1:0]       w_sel;
  feature_t                   f_sel;
  logic                       pred;
  logic                       need;
  logic signed [ERR_BITS-1:0] err_mag;
  logic signed [ERR_BITS-1:0] err_nxt;
  logic signed [SW-1:0]       bias_sum;
  logic signed [DW-1:0]       dshift;
  logic signed [SW-1:0]       w_sum;

  function automatic logic signed [WB-1:0] sat_w(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi;
    logic signed [SW-1:0] lo;
    hi = SW'($signed({1'b0, {(WB-1){1'b1}}}));
    lo = -hi - SW'(1);
    if (v > hi) begin
      return WB'(hi);
    end else if (v < lo) begin
      return WB'(lo);
    end
    return WB'(v);
  endfunction

  always_comb begin
    feat_in[0] = in_data.feature_0;
    feat_in[1] = in_data.feature_1;
    feat_in[2] = in_data.feature_2;
    feat_in[3] = in_data.feature_3;
    feat_in[4] = in_data.feature_4;
    feat_in[5] = in_data.feature_5;
    feat_in[6] = in_data.feature_6;
    feat_in[7] = in_data.feature_7;
  end

  always_comb begin
    idx      = cnt_r[IW-1:0];
    w_sel    = weight_r[idx];
    f_sel    = feat_r[idx];
    pred     = ~acc_r[AW-1];
    need     = (action_r == ACT_TRAIN) && (pred != target_r) && (eta_r != '0);
    err_mag  = $signed({1'b0, eta_r, 1'b0});
    err_nxt  = target_r ? err_mag : -err_mag;
    bias_sum = SW'(bias_r) + SW'(err_nxt);
    // arithmetic shift of the signed correction rounds toward minus infinity
    dshift   = DW'(dprod_r >>> FEAT_FRAC);
    w_sum    = SW'(weight_r[upd_idx_r]) + SW'(dshift);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        weight_r[i] <= '0;
      end
      bias_r    <= '0;
      eta_r     <= ETA_RESET;
      cnt_r     <= '0;
      pred_r    <= 1'b0;
      changed_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        eta_r <= cfg_data;
      end
      if (cmd.load) begin
        cnt_r <= '0;
      end
      if ((cmd.mac || cmd.upd) && !sts.cnt_done) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (cmd.decide) begin
        pred_r    <= pred;
        changed_r <= need;
        cnt_r     <= '0;
        if (need) begin
          bias_r <= sat_w(bias_sum);
        end
      end
      if (cmd.upd && cnt_r != '0) begin
        weight_r[upd_idx_r] <= sat_w(w_sum);
      end
      if (cmd.clear) begin
        for (int i = 0; i < NUM_FEATURES; i++) begin
          weight_r[i] <= '0;
        end
        bias_r    <= '0;
        pred_r    <= 1'b0;
        changed_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < NUM_FEATURES; i++) begin
        feat_r[i] <= feat_in[i];
      end
      action_r <= in_data.action;
      target_r <= in_data.target_class;
      acc_r    <= AW'(bias_r) <<< FEAT_FRAC;
    end
    if (cmd.mac) begin
      prod_r <= w_sel * f_sel;
      if (cnt_r != '0) begin
        acc_r <= acc_r + AW'(prod_r);
      end
    end
    if (cmd.decide) begin
      err_r <= err_nxt;
    end
    if (cmd.upd) begin
      dprod_r   <= err_r * f_sel;
      upd_idx_r <= idx;
    end
    if (cmd.res_load) begin
      out_r.predicted_class <= pred_r;
      out_r.weights_changed <= changed_r;
    end
  end

  assign sts.cnt_done    = (cnt_r == CNT_LAST);
  assign sts.need_update = need;
  assign out_data        = out_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_LAST)
    else $error("feature counter ran past the last lane");

  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> (bias_r == '0) && !pred_r && !changed_r)
    else $error("clear left bias or result flags set");

  a_no_change_hold: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.decide && !need |=> $stable(bias_r))
    else $error("bias moved without a misclassification");

endmodule

[rtl/olpt_ctrl.sv]
// Controller of the online perceptron trainer: sequences load, dot product,
// decision, weight update, clear and result hand-off. Uses olpt_pkg.
module olpt_ctrl import olpt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_action,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || out_ready;
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == ACT_CLEAR) ? S_CLR : S_MAC;
        end
      end
      S_MAC: begin
        if (sts.cnt_done) begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        state_nxt = sts.need_update ? S_UPD : S_RES;
      end
      S_UPD: begin
        if (sts.cnt_done) begin
          state_nxt = S_RES;
        end
      end
      S_CLR: begin
        state_nxt = S_RES;
      end
      S_RES: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load     = accept;
      S_MAC:   cmd.mac      = 1'b1;
      S_SIGN:  cmd.decide   = 1'b1;
      S_UPD:   cmd.upd      = 1'b1;
      S_CLR:   cmd.clear    = 1'b1;
      S_RES:   cmd.res_load = out_free;
      default: cmd          = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("accepted transfer did not start work");

  a_no_update_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SIGN) && !sts.need_update |=> state_r == S_RES)
    else $error("update entered without a misclassification");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_RES)
    else $error("result raised outside the hand-off state");

endmodule

[dv/tb.sv]
// Testbench for online_perceptron_trainer_top: random and directed samples
// checked against a fixed-point perceptron predictor. Depends on olpt_pkg.
module tb;
  import olpt_pkg::*;

  localparam int WEIGHT_BITS = 32;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 8;
  localparam int PHASE_SAMPLES = 166;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam feature_t F_MAX = 16'sh7FFF;
  localparam feature_t F_MIN = 16'sh8000;
  localparam feature_t F_ONE = 16'sh0001;
  localparam feature_t F_NEG = 16'shFFFF;
  localparam feature_t F_ZERO = 16'sh0000;

  typedef enum logic [1:0] {K_SAMPLE, K_RATE, K_DRAIN} kind_t;

  typedef struct packed {
    kind_t               kind;
    in_item_t            sample;
    logic [ETA_BITS-1:0] rate;
    logic [3:0]          hold;
  } entry_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ETA_BITS-1:0] cfg_data = '0;

  entry_t    sample_q[$];
  out_item_t pending_results[$];

  // predictor state, Q15.16 weights and bias
  longint w_model[NUM_FEATURES];
  longint bias_model;
  longint rate_model;
  int     teacher[NUM_FEATURES];

  logic       sender_calm = 1'b0;
  logic       recv_calm = 1'b0;
  logic [3:0] hold_cnt = '0;
  logic [3:0] stall_left = '0;
  int         quiet_cycles = 0;
  int         mismatches = 0;
  int         samples_sent = 0;
  int         results_seen = 0;
  int         updates_seen = 0;
  int         rate_writes = 0;

  online_perceptron_trainer_top #(
    .WEIGHT_BITS(WEIGHT_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic feature_t feature_at(in_item_t s, int i);
    logic [NUM_FEATURES*FEATURE_BITS-1:0] flat;
    flat = {s.feature_0, s.feature_1, s.feature_2, s.feature_3,
            s.feature_4, s.feature_5, s.feature_6, s.feature_7};
    return flat[(NUM_FEATURES-1-i)*FEATURE_BITS +: FEATURE_BITS];
  endfunction

  function automatic longint clamp_weight(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (WEIGHT_BITS - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Classify with the current weights, then apply the learning rule.
  function automatic out_item_t perceptron_step(in_item_t s);
    out_item_t r;
    longint    acc;
    longint    err;
    longint    f;
    int        i;
    r = '0;
    if (s.action == ACT_CLEAR) begin
      for (i = 0; i < NUM_FEATURES; i++) w_model[i] = 0;
      bias_model = 0;
      return r;
    end
    acc = bias_model <<< FEAT_FRAC;
    for (i = 0; i < NUM_FEATURES; i++) begin
      f = feature_at(s, i);
      acc += w_model[i] * f;
    end
    r.predicted_class = (acc >= 0);
    if (s.action == ACT_TRAIN && r.predicted_class != s.target_class && rate_model != 0) begin
      err = s.target_class ? 2 * rate_model : -2 * rate_model;
      r.weights_changed = 1'b1;
      bias_model = clamp_weight(bias_model + err);
      for (i = 0; i < NUM_FEATURES; i++) begin
        f = feature_at(s, i);
        // arithmetic shift of a signed value rounds toward minus infinity
        w_model[i] = clamp_weight(w_model[i] + ((err * f) >>> FEAT_FRAC));
      end
    end
    return r;
  endfunction

  function automatic in_item_t sample_fill(logic [1:0] act, feature_t even_v, feature_t odd_v,
                                           logic tgt);
    in_item_t s;
    s = '0;
    s.action = act;
    {s.feature_0, s.feature_2, s.feature_4, s.feature_6} = {4{even_v}};
    {s.feature_1, s.feature_3, s.feature_5, s.feature_7} = {4{odd_v}};
    s.target_class = tgt;
    return s;
  endfunction

  function automatic in_item_t sample_random(logic [1:0] act, logic tgt);
    in_item_t s;
    s = '0;
    s.action = act;
    {s.feature_0, s.feature_1, s.feature_2, s.feature_3,
     s.feature_4, s.feature_5, s.feature_6, s.feature_7} =
      {$urandom(), $urandom(), $urandom(), $urandom()};
    s.target_class = tgt;
    return s;
  endfunction

  // Label from a hidden separating plane, so training sequences converge.
  function automatic logic teacher_label(in_item_t s);
    longint acc;
    longint f;
    int     i;
    acc = 0;
    for (i = 0; i < NUM_FEATURES; i++) begin
      f = feature_at(s, i);
      acc += teacher[i] * f;
    end
    return acc >= 0;
  endfunction

  task automatic queue_entry(kind_t k, in_item_t s, logic [ETA_BITS-1:0] v);
    entry_t e;
    e.kind = k;
    e.sample = s;
    e.rate = v;
    e.hold = sender_calm ? 4'd0 : 4'($urandom_range(0, 14));
    sample_q = {sample_q, e};
  endtask

  task automatic note_mismatch(string what, logic [1:0] want, logic [1:0] got);
    if (mismatches < 10)
      $display("[%0t] %s: expected %b, got %b", $time, what, want, got);
    mismatches++;
  endtask

  // Driver: present queued samples, and write the rate only once drained.
  always @(posedge clk) begin
    entry_t head;
    if (!rst_n) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      hold_cnt <= '0;
    end else begin
      if (in_valid && in_ready) begin
        pending_results = {pending_results, perceptron_step(in_data)};
        samples_sent++;
      end
      if (cfg_valid && cfg_ready) begin
        rate_model = cfg_data;
        rate_writes++;
      end
      if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
        // hold the transfer until it is taken
      end else if (sample_q.size() == 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else begin
        head = sample_q[0];
        if (head.kind == K_SAMPLE && hold_cnt < head.hold) begin
          in_valid <= 1'b0;
          cfg_valid <= 1'b0;
          hold_cnt <= hold_cnt + 1'b1;
        end else if (head.kind == K_SAMPLE) begin
          in_valid <= 1'b1;
          in_data <= head.sample;
          cfg_valid <= 1'b0;
          hold_cnt <= '0;
          void'(sample_q.pop_front());
        end else if (pending_results.size() != 0) begin
          in_valid <= 1'b0;
          cfg_valid <= 1'b0;
        end else if (head.kind == K_RATE) begin
          in_valid <= 1'b0;
          cfg_valid <= 1'b1;
          cfg_data <= head.rate;
          void'(sample_q.pop_front());
        end else begin
          in_valid <= 1'b0;
          cfg_valid <= 1'b0;
          void'(sample_q.pop_front());
        end
      end
    end
  end

  // Monitor: compare each result transfer, then draw the next stall.
  always @(posedge clk) begin
    out_item_t   want;
    int unsigned pause;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= '0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_data.weights_changed) updates_seen++;
        if (pending_results.size() == 0) begin
          note_mismatch("unexpected result", 2'bxx, out_data);
        end else begin
          want = pending_results.pop_front();
          if (want.predicted_class !== out_data.predicted_class)
            note_mismatch("predicted_class", want.predicted_class, out_data.predicted_class);
          if (want.weights_changed !== out_data.weights_changed)
            note_mismatch("weights_changed", want.weights_changed, out_data.weights_changed);
        end
        if ($urandom_range(0, 39) == 0) recv_calm <= !recv_calm;
      end
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1'b1;
      end else if (out_valid && out_ready) begin
        pause = recv_calm ? 0 : $urandom_range(0, 14);
        out_ready <= (pause == 0);
        stall_left <= (pause == 0) ? 4'd0 : 4'(pause - 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned         p;
    int unsigned         k;
    int unsigned         j;
    int unsigned         roll;
    logic [ETA_BITS-1:0] rate;
    in_item_t            s;

    for (j = 0; j < NUM_FEATURES; j++) w_model[j] = 0;
    bias_model = 0;
    rate_model = ETA_RESET;

    // zero weights at reset: zero sum classifies as +1
    queue_entry(K_SAMPLE, sample_fill(ACT_PREDICT, F_ZERO, F_ZERO, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_ZERO, F_ZERO, 1'b1), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_ZERO, F_ZERO, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_PREDICT, F_ZERO, F_ZERO, 1'b1), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MAX, F_MAX, 1'b1), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MIN, F_MIN, 1'b1), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MIN, F_MIN, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_SPARE, F_MAX, F_MIN, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_SPARE, F_MIN, F_MAX, 1'b1), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_ONE, F_NEG, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_NEG, F_ONE, 1'b1), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_CLEAR, F_MAX, F_MAX, 1'b1), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_PREDICT, F_MIN, F_MAX, 1'b0), '0);
    queue_entry(K_RATE, '0, 16'hFFFF);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MAX, F_MIN, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MIN, F_MAX, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MAX, F_MAX, 1'b1), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MIN, F_MIN, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_PREDICT, F_MAX, F_MIN, 1'b1), '0);
    // zero rate: misclassified samples must leave the weights alone
    queue_entry(K_RATE, '0, 16'd0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MAX, F_MAX, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MIN, F_MIN, 1'b1), '0);
    queue_entry(K_RATE, '0, 16'd1);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_MAX, F_MAX, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_TRAIN, F_ONE, F_ONE, 1'b0), '0);
    queue_entry(K_SAMPLE, sample_fill(ACT_CLEAR, F_ZERO, F_ZERO, 1'b0), '0);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0, 7:    rate = 16'hFFFF;
        1:       rate = 16'd1;
        2:       rate = 16'd0;
        3:       rate = ETA_RESET;
        4:       rate = 16'h8000;
        default: rate = 16'($urandom_range(1, 65535));
      endcase
      queue_entry(K_RATE, '0, rate);
      for (j = 0; j < NUM_FEATURES; j++) teacher[j] = $urandom_range(0, 4000) - 2000;
      for (k = 0; k < PHASE_SAMPLES; k++) begin
        if (k % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
        if (p % 2 == 1 && k == PHASE_SAMPLES / 2) queue_entry(K_DRAIN, '0, '0);
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          s = sample_random(ACT_TRAIN, 1'b0);
          // flip a few labels so training keeps making mistakes
          s.target_class = teacher_label(s) ^ (roll < 3);
        end else if (roll < 88) begin
          s = sample_random(ACT_PREDICT, 1'($urandom_range(0, 1)));
        end else if (roll < 92) begin
          s = sample_random(ACT_SPARE, 1'($urandom_range(0, 1)));
        end else if (roll < 95) begin
          s = sample_random(ACT_CLEAR, 1'($urandom_range(0, 1)));
        end else begin
          s = sample_random(ACT_TRAIN, 1'($urandom_range(0, 1)));
        end
        queue_entry(K_SAMPLE, s, '0);
      end
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (sample_q.size() != 0 || in_valid || cfg_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d results from %0d samples; %0d of them updated the weights.",
             results_seen, samples_sent, updates_seen);
    $display("Learning rate written %0d times, covering 0, 1, 655 and 65535.", rate_writes);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
